// File: design/hof_pkg.sv
// Shared types and constants for the horizon object filter.
// No dependencies.
package hof_pkg;

  localparam int unsigned CoordW    = 11;
  localparam int unsigned ProdW     = 43;
  localparam int unsigned LineW     = 46;
  localparam int unsigned QShift    = 16;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned CfgIndexW = 2;

  localparam logic [CoordW-1:0] ImgHeight   = 11'd240;
  localparam logic [CoordW-1:0] ImgWidth    = 11'd520;
  localparam logic [CoordW-1:0] BoxEmptyMin = 11'd1000;
  localparam logic [CoordW-1:0] BoxEmptyMax = 11'h7FF;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_LINE_SLOPE     = 2'd0,
    CFG_LINE_INTERCEPT = 2'd1,
    CFG_MARGIN         = 2'd2,
    CFG_UNUSED         = 2'd3
  } cfg_index_e;

  typedef struct packed {
    logic signed [CoordW-1:0] min_col;
    logic signed [CoordW-1:0] max_col;
    logic signed [CoordW-1:0] min_row;
    logic signed [CoordW-1:0] max_row;
  } box_t;

  typedef struct packed {
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    logic        [9:0]  margin;
  } cfg_t;

endpackage

// File: design/hof_front.sv
// Front end: accepts pixels and keeps the bounding box of object pixels.
// On the last pixel it hands the finished box to the queue. Uses hof_pkg.
module hof_front import hof_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] row_i,
  input  logic [9:0] column_i,
  input  logic [7:0] pixel_value_i,
  input  logic       last_pixel_i,
  input  logic       q_full_i,
  output logic       push_o,
  output box_t       push_box_o
);

  box_t box_q, box_d, box_upd;
  logic accept;
  logic hit;
  logic signed [CoordW-1:0] r, c;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign r          = $signed({3'b000, row_i});
  assign c          = $signed({1'b0, column_i});
  assign hit        = (pixel_value_i != 8'd0) && ({3'b000, row_i} < ImgHeight)
                      && ({1'b0, column_i} < ImgWidth);

  always_comb begin
    box_upd = box_q;
    if (hit) begin
      if (r > box_q.max_row) box_upd.max_row = r;
      if (r < box_q.min_row) box_upd.min_row = r;
      if (c > box_q.max_col) box_upd.max_col = c;
      if (c < box_q.min_col) box_upd.min_col = c;
    end
  end

  always_comb begin
    box_d = box_q;
    if (accept) begin
      if (last_pixel_i) begin
        box_d.min_col = $signed(BoxEmptyMin);
        box_d.max_col = $signed(BoxEmptyMax);
        box_d.min_row = $signed(BoxEmptyMin);
        box_d.max_row = $signed(BoxEmptyMax);
      end else begin
        box_d = box_upd;
      end
    end
  end

  assign push_o     = accept & last_pixel_i;
  assign push_box_o = box_upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q.min_col <= $signed(BoxEmptyMin);
      box_q.max_col <= $signed(BoxEmptyMax);
      box_q.min_row <= $signed(BoxEmptyMin);
      box_q.max_row <= $signed(BoxEmptyMax);
    end else begin
      box_q <= box_d;
    end
  end

endmodule

// File: design/hof_queue.sv
// Two-entry queue of finished boxes between front and back end.
// Uses hof_pkg.
module hof_queue import hof_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  box_t push_box_i,
  output logic full_o,
  output logic head_valid_o,
  output box_t head_box_o,
  input  logic pop_i
);

  box_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o       = (count_q == 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_box_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i & ~full_o;
  assign do_pop       = pop_i & head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_box_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: design/hof_back.sv
// Back end: tests the four box corners against the horizon line.
// Multiply stage, then add/compare into the output register. Uses hof_pkg.
module hof_back import hof_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic head_valid_i,
  input  box_t head_box_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic filter_out_o
);

  logic                     a_valid_q, a_valid_d;
  logic signed [ProdW-1:0]  prod_min_q, prod_max_q;
  logic signed [CoordW-1:0] y_min_q, y_max_q;
  logic                     o_valid_q, o_valid_d;
  logic                     filt_q, filt_d;
  logic                     o_ready, a_ready;

  logic signed [LineW-1:0] pad, icpt;
  logic signed [LineW-1:0] line_min, line_max;
  logic signed [LineW-1:0] lo_min, hi_min, lo_max, hi_max;
  logic signed [LineW-1:0] ly_min, ly_max;
  logic                    all_above, all_below;

  assign o_ready = ~o_valid_q | ~out_stall_i;
  assign a_ready = ~a_valid_q | o_ready;
  assign pop_o   = head_valid_i & a_ready;

  assign pad      = $signed({20'd0, cfg_i.margin, 16'd0});
  assign icpt     = LineW'(cfg_i.intercept);
  assign line_min = LineW'(prod_min_q) + icpt;
  assign line_max = LineW'(prod_max_q) + icpt;
  assign lo_min   = line_min - pad;
  assign hi_min   = line_min + pad;
  assign lo_max   = line_max - pad;
  assign hi_max   = line_max + pad;
  assign ly_min   = LineW'(y_min_q) <<< QShift;
  assign ly_max   = LineW'(y_max_q) <<< QShift;

  assign all_above = (ly_min < lo_min) && (ly_min < lo_max)
                     && (ly_max < lo_min) && (ly_max < lo_max);
  assign all_below = (ly_min > hi_min) && (ly_min > hi_max)
                     && (ly_max > hi_min) && (ly_max > hi_max);

  always_comb begin
    a_valid_d = a_valid_q;
    if (a_ready) a_valid_d = head_valid_i;
    o_valid_d = o_valid_q;
    filt_d    = filt_q;
    if (o_ready) begin
      o_valid_d = a_valid_q;
      filt_d    = all_above | all_below;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      prod_min_q <= ProdW'(cfg_i.slope) * ProdW'(head_box_i.min_col);
      prod_max_q <= ProdW'(cfg_i.slope) * ProdW'(head_box_i.max_col);
      y_min_q    <= head_box_i.min_row;
      y_max_q    <= head_box_i.max_row;
    end
    filt_q <= filt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  assign out_valid_o  = o_valid_q;
  assign filter_out_o = filt_q;

endmodule

// File: design/horizon_object_filter_top.sv
// Horizon object filter top level: config registers, front, queue, back.
// Takes one pixel per cycle; the queue stalls input only when two boxes wait.
// A finished box passes the queue, the multiply stage and the output register in turn.
// Throughput: one pixel per cycle while not stalled; results at most one per cycle.
// Reset: asynchronous active low; empties the box and queue and returns the
// config registers to their reset values.
module horizon_object_filter_top import hof_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           row_i,
  input  logic [9:0]           column_i,
  input  logic [7:0]           pixel_value_i,
  input  logic                 last_pixel_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 filter_out_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i
);

  cfg_t cfg_q, cfg_d;
  logic q_full, push, head_valid, pop;
  box_t push_box, head_box;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_LINE_SLOPE:     cfg_d.slope     = $signed(cfg_wdata_i);
        CFG_LINE_INTERCEPT: cfg_d.intercept = $signed(cfg_wdata_i);
        CFG_MARGIN:         cfg_d.margin    = cfg_wdata_i[9:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slope     <= 32'sd0;
      cfg_q.intercept <= 32'sd7864320;
      cfg_q.margin    <= 10'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  hof_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .row_i         (row_i),
    .column_i      (column_i),
    .pixel_value_i (pixel_value_i),
    .last_pixel_i  (last_pixel_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .push_box_o    (push_box)
  );

  hof_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_box_i   (push_box),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_box_o   (head_box),
    .pop_i        (pop)
  );

  hof_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_box_i   (head_box),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .filter_out_o (filter_out_o)
  );

endmodule
